[rtl/core/owtsd_pkg.sv]
// ----------------------------------------------------------------------------
// owtsd_pkg
// Shared constants and types for the scratchpad temperature decoder.
// ----------------------------------------------------------------------------
package owtsd_pkg;

  // Result width and the unsigned quotient magnitude width of the fraction divider.
  localparam int unsigned ValueW = 35;
  localparam int unsigned QuotW  = 28;

  // CRC-8 over bytes 0 to 7, shifted LSB first, two bits per cycle.
  localparam int unsigned CrcBits   = 64;
  localparam int unsigned CrcDigit  = 2;
  localparam int unsigned CrcCycles = CrcBits / CrcDigit;
  localparam logic [7:0]  CrcPoly   = 8'h8C;

  // Scale factors in micro-degrees.
  localparam int unsigned KTwelve    = 62500;
  localparam int unsigned KHalf      = 500000;
  localparam int unsigned HalfOffset = 250000;
  localparam int unsigned FracScale  = 1000000;

  // Sensor kind codes.
  localparam logic KindHalf   = 1'b0;
  localparam logic KindTwelve = 1'b1;

  // Control for a serial datapath unit.
  typedef struct packed {
    logic load;
    logic step;
  } step_ctrl_t;

endpackage

[rtl/core/owtsd_crc8.sv]
// ----------------------------------------------------------------------------
// owtsd_crc8
// Serial Dallas CRC-8 over a 64-bit scratchpad prefix, two bits per cycle.
// ----------------------------------------------------------------------------
module owtsd_crc8 (
  input  logic                    clk_i,
  input  owtsd_pkg::step_ctrl_t   ctrl_i,
  input  logic [63:0]             data_i,
  output logic [7:0]              crc_o
);

  logic [63:0] sh_q, sh_d;
  logic [7:0]  crc_q, crc_d;

  always_comb begin
    logic [7:0] c;
    logic       mix;
    c = crc_q;
    for (int i = 0; i < int'(owtsd_pkg::CrcDigit); i++) begin
      mix = c[0] ^ sh_q[i];
      c   = {1'b0, c[7:1]} ^ (mix ? owtsd_pkg::CrcPoly : 8'h00);
    end
    sh_d  = sh_q;
    crc_d = crc_q;
    if (ctrl_i.load) begin
      sh_d  = data_i;
      crc_d = '0;
    end else if (ctrl_i.step) begin
      sh_d  = sh_q >> owtsd_pkg::CrcDigit;
      crc_d = c;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    crc_q <= crc_d;
  end

  assign crc_o = crc_q;

endmodule

[rtl/core/owtsd_div.sv]
// ----------------------------------------------------------------------------
// owtsd_div
// Restoring divider, one quotient bit per cycle, for the count fraction
// ((count_per_c - remain_count) * 1000000) / count_per_c, truncated to zero.
// ----------------------------------------------------------------------------
module owtsd_div (
  input  logic                                   clk_i,
  input  owtsd_pkg::step_ctrl_t                  ctrl_i,
  input  logic [7:0]                             cpc_i,
  input  logic [7:0]                             crem_i,
  output logic signed [owtsd_pkg::QuotW:0]       quot_o
);

  localparam int unsigned QW = owtsd_pkg::QuotW;

  logic [7:0]    divisor_q, divisor_d;
  logic          neg_q, neg_d;
  logic [7:0]    rem_q, rem_d;
  logic [QW-1:0] acc_q, acc_d;

  logic [8:0]    diff_in;
  logic [7:0]    mag;
  logic [8:0]    rem_sh;
  logic [8:0]    rem_sub;
  logic          fits;

  assign diff_in = {1'b0, cpc_i} - {1'b0, crem_i};
  assign mag     = diff_in[8] ? 8'(-diff_in) : diff_in[7:0];
  assign rem_sh  = {rem_q, acc_q[QW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_q};
  assign fits    = rem_sh >= {1'b0, divisor_q};

  always_comb begin
    divisor_d = divisor_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    if (ctrl_i.load) begin
      divisor_d = cpc_i;
      neg_d     = diff_in[8];
      rem_d     = '0;
      acc_d     = QW'(mag) * QW'(owtsd_pkg::FracScale);
    end else if (ctrl_i.step) begin
      rem_d = fits ? rem_sub[7:0] : rem_sh[7:0];
      acc_d = {acc_q[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    neg_q     <= neg_d;
    rem_q     <= rem_d;
    acc_q     <= acc_d;
  end

  // Magnitude division then sign restore gives truncation toward zero.
  assign quot_o = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

[rtl/core/onewire_temp_scratchpad_decode.sv]
// ----------------------------------------------------------------------------
// onewire_temp_scratchpad_decode
// Checks a nine-byte 1-Wire scratchpad and converts its temperature.
// ----------------------------------------------------------------------------
// One scratchpad is decoded at a time. A request is taken in the idle state
// and goes through the serial pass, in which the CRC-8 over bytes 0 to 7 runs
// at two bits per cycle and sets the length, then through the final add in
// the finish state, whose result is loaded into the output register. The
// fraction divider runs inside the same pass, one quotient bit per cycle.
// The block is ready again as the result is loaded, whether or not it has
// been taken; a result that finishes while the previous one still waits is
// held until the output frees up. A failed CRC returns the last good
// temperature with crc_ok_o low.
module onewire_temp_scratchpad_decode (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [7:0]                            temp_lsb_i,
  input  logic [7:0]                            temp_msb_i,
  input  logic [7:0]                            alarm_high_i,
  input  logic [7:0]                            alarm_low_i,
  input  logic [7:0]                            sensor_cfg_byte_i,
  input  logic [7:0]                            reserved_byte_i,
  input  logic [7:0]                            remain_count_i,
  input  logic [7:0]                            count_per_c_i,
  input  logic [7:0]                            crc_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [owtsd_pkg::ValueW-1:0]   temperature_micro_c_o,
  output logic                                  crc_ok_o
);

  localparam int unsigned VW   = owtsd_pkg::ValueW;
  localparam int unsigned CntW = $clog2(owtsd_pkg::CrcCycles);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   kind_q;
  logic                   out_valid_q, out_valid_d;
  logic                   crc_ok_q, crc_ok_d;
  logic signed [VW-1:0]   last_value_q, last_value_d;

  logic signed [VW-1:0]   prod_q;
  logic                   use_frac_q;
  logic [7:0]             crc_exp_q;

  logic                   accept;
  logic                   fin_fire;
  logic                   crc_match;
  logic [7:0]             crc_val;
  logic signed [owtsd_pkg::QuotW:0] quot;
  owtsd_pkg::step_ctrl_t  crc_ctrl, div_ctrl;

  logic                   cpc_nz;
  logic signed [15:0]     raw_sel;
  logic signed [20:0]     k_sel;
  logic signed [36:0]     prod_full;
  logic signed [VW-1:0]   frac_term;
  logic signed [VW-1:0]   fin_value;

  assign accept   = in_valid_i && in_ready_o;
  assign fin_fire = (state_q == StFin) && (!out_valid_q || out_ready_i);

  assign crc_ctrl.load = accept;
  assign crc_ctrl.step = (state_q == StRun);
  assign div_ctrl.load = accept;
  assign div_ctrl.step = (state_q == StRun) && (cnt_q < CntW'(owtsd_pkg::QuotW));

  owtsd_crc8 u_crc (
    .clk_i  (clk_i),
    .ctrl_i (crc_ctrl),
    .data_i ({count_per_c_i, remain_count_i, reserved_byte_i, sensor_cfg_byte_i,
              alarm_low_i, alarm_high_i, temp_msb_i, temp_lsb_i}),
    .crc_o  (crc_val)
  );

  owtsd_div u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .cpc_i  (count_per_c_i),
    .crem_i (remain_count_i),
    .quot_o (quot)
  );

  // Scaled raw reading, formed straight from the request.
  assign cpc_nz = (count_per_c_i != 8'd0);

  always_comb begin
    if (kind_q == owtsd_pkg::KindTwelve) begin
      raw_sel = $signed({temp_msb_i, temp_lsb_i});
      k_sel   = 21'(owtsd_pkg::KTwelve);
    end else if (cpc_nz) begin
      raw_sel = $signed({temp_msb_i, temp_lsb_i[7:1], 1'b0});
      k_sel   = 21'(owtsd_pkg::KHalf);
    end else begin
      raw_sel = $signed({temp_msb_i, temp_lsb_i});
      k_sel   = 21'(owtsd_pkg::KHalf);
    end
  end

  assign prod_full = raw_sel * k_sel;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q     <= prod_full[VW-1:0];
      use_frac_q <= (kind_q == owtsd_pkg::KindHalf) && cpc_nz;
      crc_exp_q  <= crc_byte_i;
    end
  end

  assign crc_match = (crc_val == crc_exp_q);
  assign frac_term = use_frac_q ? (VW'(quot) - VW'(owtsd_pkg::HalfOffset)) : '0;
  assign fin_value = prod_q + frac_term;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    crc_ok_d     = crc_ok_q;
    last_value_d = last_value_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          cnt_d   = '0;
        end
      end
      StRun: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(owtsd_pkg::CrcCycles - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (fin_fire) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          crc_ok_d    = crc_match;
          if (crc_match) begin
            last_value_d = fin_value;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      kind_q       <= owtsd_pkg::KindHalf;
      out_valid_q  <= 1'b0;
      crc_ok_q     <= 1'b0;
      last_value_q <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      crc_ok_q     <= crc_ok_d;
      last_value_q <= last_value_d;
      if (cfg_we_i) begin
        kind_q <= cfg_wdata_i;
      end
    end
  end

  assign in_ready_o            = (state_q == StIdle);
  assign out_valid_o           = out_valid_q;
  assign crc_ok_o              = crc_ok_q;
  assign temperature_micro_c_o = last_value_q;

  // A request always starts a full CRC pass.
  a_accept_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StRun) && (cnt_q == '0))
    else $error("accepted request did not start the serial pass");

  // The pass ends after the last CRC digit.
  a_run_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) && (cnt_q == CntW'(owtsd_pkg::CrcCycles - 1)) |=> state_q == StFin)
    else $error("serial pass did not end on the last digit");

  // A failed check keeps the last good temperature.
  a_hold_bad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire && !crc_match |=> !crc_ok_o && $stable(temperature_micro_c_o))
    else $error("temperature changed on a CRC mismatch");

  // A finished result waits while the previous one is still pending.
  a_fin_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) && out_valid_o && !out_ready_i |=> state_q == StFin)
    else $error("result overwrote a pending output");

endmodule

[verif/onewire_temp_scratchpad_decode_tb.sv]
// ----------------------------------------------------------------------------
// onewire_temp_scratchpad_decode_tb
// Drives nine-byte scratchpads into the decoder under both sensor kinds and
// checks every reading against an in-bench CRC-8 and temperature predictor.
// The sender runs in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module onewire_temp_scratchpad_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxPrinted  = 40;

  typedef struct packed {
    logic [7:0] temp_lsb;
    logic [7:0] temp_msb;
    logic [7:0] alarm_high;
    logic [7:0] alarm_low;
    logic [7:0] sensor_cfg;
    logic [7:0] reserved;
    logic [7:0] remain_count;
    logic [7:0] count_per_c;
    logic [7:0] crc;
  } scratchpad_t;

  typedef struct packed {
    logic signed [owtsd_pkg::ValueW-1:0] temperature;
    logic                                crc_ok;
  } reading_t;

  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     cfg_we_i          = 1'b0;
  logic                     cfg_wdata_i       = 1'b0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               temp_lsb_i        = 8'h00;
  logic [7:0]               temp_msb_i        = 8'h00;
  logic [7:0]               alarm_high_i      = 8'h00;
  logic [7:0]               alarm_low_i       = 8'h00;
  logic [7:0]               sensor_cfg_byte_i = 8'h00;
  logic [7:0]               reserved_byte_i   = 8'h00;
  logic [7:0]               remain_count_i    = 8'h00;
  logic [7:0]               count_per_c_i     = 8'h00;
  logic [7:0]               crc_byte_i        = 8'h00;
  logic                     out_valid_o;
  logic                     out_ready_i       = 1'b0;
  logic signed [owtsd_pkg::ValueW-1:0] temperature_micro_c_o;
  logic                     crc_ok_o;

  // Predictor state, mirrored from the block.
  logic                     sensor_kind = owtsd_pkg::KindHalf;
  logic signed [owtsd_pkg::ValueW-1:0] last_temp = '0;

  reading_t    pending_readings[$];
  int unsigned error_count   = 0;
  int unsigned sent_count    = 0;
  int unsigned good_count    = 0;
  int unsigned checked_count = 0;
  int unsigned cycle_count   = 0;
  int unsigned ready_left    = 0;
  logic        rx_always_ready = 1'b0;

  onewire_temp_scratchpad_decode dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .temp_lsb_i            (temp_lsb_i),
    .temp_msb_i            (temp_msb_i),
    .alarm_high_i          (alarm_high_i),
    .alarm_low_i           (alarm_low_i),
    .sensor_cfg_byte_i     (sensor_cfg_byte_i),
    .reserved_byte_i       (reserved_byte_i),
    .remain_count_i        (remain_count_i),
    .count_per_c_i         (count_per_c_i),
    .crc_byte_i            (crc_byte_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .temperature_micro_c_o (temperature_micro_c_o),
    .crc_ok_o              (crc_ok_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Dallas CRC-8, reflected, LSB first, over bytes 0 to 7.
  function automatic logic [7:0] scratchpad_crc(input scratchpad_t sp);
    logic [7:0] body [8];
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    int         k;
    body = '{sp.temp_lsb, sp.temp_msb, sp.alarm_high, sp.alarm_low,
             sp.sensor_cfg, sp.reserved, sp.remain_count, sp.count_per_c};
    crc = 8'h00;
    foreach (body[i]) begin
      b = body[i];
      for (k = 0; k < 8; k++) begin
        mix = crc[0] ^ b[0];
        crc = crc >> 1;
        if (mix) begin
          crc = crc ^ owtsd_pkg::CrcPoly;
        end
        b = b >> 1;
      end
    end
    return crc;
  endfunction

  // All products and the fraction are taken at 64 bits; division truncates
  // toward zero, which is what a signed longint divide does.
  function automatic logic signed [owtsd_pkg::ValueW-1:0] decode_temperature(
      input scratchpad_t sp, input logic kind);
    logic signed [15:0] raw;
    logic signed [15:0] even_raw;
    longint             cpc;
    longint             crem;
    longint             value;
    raw      = {sp.temp_msb, sp.temp_lsb};
    even_raw = {sp.temp_msb, sp.temp_lsb[7:1], 1'b0};
    cpc      = longint'(sp.count_per_c);
    crem     = longint'(sp.remain_count);
    if (kind == owtsd_pkg::KindTwelve) begin
      value = longint'(raw) * longint'(owtsd_pkg::KTwelve);
    end else if (cpc != 0) begin
      value = longint'(even_raw) * longint'(owtsd_pkg::KHalf)
            - longint'(owtsd_pkg::HalfOffset)
            + ((cpc - crem) * longint'(owtsd_pkg::FracScale)) / cpc;
    end else begin
      value = longint'(raw) * longint'(owtsd_pkg::KHalf);
    end
    return value[owtsd_pkg::ValueW-1:0];
  endfunction

  function automatic scratchpad_t make_pad(input logic [7:0] lsb, input logic [7:0] msb,
                                           input logic [7:0] crem, input logic [7:0] cpc);
    scratchpad_t sp;
    sp = '{lsb, msb, 8'h4B, 8'h46, 8'h7F, 8'hFF, crem, cpc, 8'h00};
    sp.crc = scratchpad_crc(sp);
    return sp;
  endfunction

  function automatic scratchpad_t random_pad();
    scratchpad_t sp;
    int unsigned pick;
    int unsigned bit_pos;
    sp.temp_lsb     = 8'($urandom);
    sp.temp_msb     = 8'($urandom);
    sp.alarm_high   = 8'($urandom);
    sp.alarm_low    = 8'($urandom);
    sp.sensor_cfg   = 8'($urandom);
    sp.reserved     = 8'($urandom);
    sp.remain_count = 8'($urandom);
    sp.count_per_c  = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      sp.count_per_c = 8'h00;
    end else if (pick < 25) begin
      sp.count_per_c = 8'($urandom_range(1, 16));
    end else if (pick < 45) begin
      // Typical conversion: remainder not above the counts per degree.
      sp.count_per_c  = 8'($urandom_range(1, 255));
      sp.remain_count = 8'($urandom_range(0, sp.count_per_c));
    end
    sp.crc = scratchpad_crc(sp);
    bit_pos = $urandom_range(0, 7);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      sp.crc[bit_pos] = ~sp.crc[bit_pos];
    end else if (pick < 13) begin
      sp.crc = 8'($urandom);
    end else if (pick < 18) begin
      sp.remain_count[bit_pos] = ~sp.remain_count[bit_pos];
    end
    return sp;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("[%0d] mismatch: %s", cycle_count, what);
    end
  endtask

  // Called in the step of a rising edge; returns in the step of acceptance
  // with valid still high, so a following request keeps it up.
  task automatic send_scratchpad(input scratchpad_t sp);
    reading_t r;
    in_valid_i        <= 1'b1;
    temp_lsb_i        <= sp.temp_lsb;
    temp_msb_i        <= sp.temp_msb;
    alarm_high_i      <= sp.alarm_high;
    alarm_low_i       <= sp.alarm_low;
    sensor_cfg_byte_i <= sp.sensor_cfg;
    reserved_byte_i   <= sp.reserved;
    remain_count_i    <= sp.remain_count;
    count_per_c_i     <= sp.count_per_c;
    crc_byte_i        <= sp.crc;
    do @(posedge clk_i); while (!in_ready_o);
    r.crc_ok = (scratchpad_crc(sp) == sp.crc);
    if (r.crc_ok) begin
      last_temp = decode_temperature(sp, sensor_kind);
      good_count++;
    end
    r.temperature = last_temp;
    pending_readings.push_back(r);
    sent_count++;
  endtask

  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_sensor_kind(input logic kind);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= kind;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sensor_kind  = kind;
  endtask

  // Before any good scratchpad the reading must be the reset value.
  task automatic test_reset_hold();
    scratchpad_t sp;
    write_sensor_kind(owtsd_pkg::KindHalf);
    sp = '{default: 8'h00};
    sp.crc = 8'h01;
    send_scratchpad(sp);
    sp = make_pad(8'h32, 8'h00, 8'h0C, 8'h10);
    sp.crc = ~sp.crc;
    send_scratchpad(sp);
    drain_decoder();
  endtask

  task automatic test_half_degree_edges();
    scratchpad_t sp;
    write_sensor_kind(owtsd_pkg::KindHalf);
    sp = '{default: 8'h00};
    send_scratchpad(sp);
    send_scratchpad(make_pad(8'hFF, 8'h7F, 8'h00, 8'hFF));
    send_scratchpad(make_pad(8'h00, 8'h80, 8'hFF, 8'h01));
    send_scratchpad(make_pad(8'h01, 8'h80, 8'h22, 8'h00));
    send_scratchpad(make_pad(8'hFF, 8'h7F, 8'h10, 8'h00));
    // Remainder above the divisor gives a negative fraction.
    send_scratchpad(make_pad(8'h33, 8'h00, 8'h05, 8'h03));
    send_scratchpad(make_pad(8'hCF, 8'hFF, 8'h03, 8'h07));
    send_scratchpad(make_pad(8'h32, 8'h00, 8'h0C, 8'h10));
    sp = '{default: 8'hFF};
    sp.crc = scratchpad_crc(sp);
    send_scratchpad(sp);
    drain_decoder();
  endtask

  task automatic test_crc_mismatch_hold();
    scratchpad_t sp;
    send_scratchpad(make_pad(8'hAA, 8'h00, 8'h09, 8'h10));
    sp = make_pad(8'h55, 8'hFF, 8'h01, 8'h10);
    sp.crc = sp.crc ^ 8'h80;
    send_scratchpad(sp);
    sp = make_pad(8'h10, 8'h00, 8'h02, 8'h10);
    sp.alarm_low = sp.alarm_low ^ 8'h01;
    send_scratchpad(sp);
    drain_decoder();
  endtask

  task automatic test_twelve_bit_edges();
    scratchpad_t sp;
    write_sensor_kind(owtsd_pkg::KindTwelve);
    send_scratchpad(make_pad(8'hFF, 8'h7F, 8'h0C, 8'h10));
    send_scratchpad(make_pad(8'h00, 8'h80, 8'h0C, 8'h10));
    send_scratchpad(make_pad(8'hFF, 8'hFF, 8'h00, 8'h00));
    send_scratchpad(make_pad(8'h01, 8'h00, 8'hFF, 8'h00));
    send_scratchpad(make_pad(8'h50, 8'h05, 8'h0C, 8'h10));
    sp = make_pad(8'h91, 8'h01, 8'h0C, 8'h10);
    sp.crc = sp.crc ^ 8'h01;
    send_scratchpad(sp);
    drain_decoder();
  endtask

  task automatic test_random_traffic();
    logic        kinds [6];
    int unsigned burst_left;
    int unsigned gap;
    int          p;
    int          n;
    kinds = '{owtsd_pkg::KindHalf, owtsd_pkg::KindTwelve, owtsd_pkg::KindTwelve,
              owtsd_pkg::KindHalf, owtsd_pkg::KindTwelve, owtsd_pkg::KindHalf};
    burst_left = 0;
    for (p = 0; p < 6; p++) begin
      write_sensor_kind(kinds[p]);
      // One phase runs with neither side idling.
      rx_always_ready = (p == 3);
      for (n = 0; n < 225; n++) begin
        send_scratchpad(random_pad());
        if (p != 3) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            if (gap != 0) begin
              in_valid_i <= 1'b0;
              repeat (gap) @(posedge clk_i);
            end
          end else begin
            burst_left--;
          end
        end
      end
      drain_decoder();
    end
    rx_always_ready = 1'b0;
  endtask

  // Receiver: checks each accepted reading, then picks its next stall state.
  always @(posedge clk_i) begin
    reading_t    want;
    int unsigned pick;
    if (rst_ni && out_valid_o && out_ready_i) begin
      checked_count++;
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("reading %0d with none pending",
                                  temperature_micro_c_o));
      end else begin
        want = pending_readings.pop_front();
        if (temperature_micro_c_o !== want.temperature) begin
          report_mismatch($sformatf("temperature %0d, predicted %0d",
                                    temperature_micro_c_o, want.temperature));
        end
        if (crc_ok_o !== want.crc_ok) begin
          report_mismatch($sformatf("crc_ok %b, predicted %b", crc_ok_o, want.crc_ok));
        end
      end
    end
    if (rx_always_ready) begin
      out_ready_i <= 1'b1;
      ready_left   = 0;
    end else if (ready_left != 0) begin
      ready_left--;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        out_ready_i <= 1'b1;
        ready_left   = $urandom_range(50, 300);
      end else if (pick < 6) begin
        out_ready_i <= 1'b1;
        ready_left   = $urandom_range(0, 20);
      end else if (pick < 9) begin
        out_ready_i <= 1'b0;
        ready_left   = $urandom_range(0, 40);
      end else begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d readings pending",
               cycle_count, pending_readings.size());
      $display("onewire_temp_scratchpad_decode_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_hold();
    test_half_degree_edges();
    test_crc_mismatch_hold();
    test_twelve_bit_edges();
    test_random_traffic();
    if (pending_readings.size() != 0) begin
      report_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
    end
    $display("sent %0d scratchpads (%0d with a good CRC), checked %0d readings",
             sent_count, good_count, checked_count);
    $display("covered both sensor kinds, CRC failures and bursty traffic with stalls");
    if (error_count == 0) begin
      $display("onewire_temp_scratchpad_decode_tb passed");
    end else begin
      $display("onewire_temp_scratchpad_decode_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/owtsd_pkg.sv
rtl/core/owtsd_crc8.sv
rtl/core/owtsd_div.sv
rtl/core/onewire_temp_scratchpad_decode.sv
verif/onewire_temp_scratchpad_decode_tb.sv
